// ===== hw/rtl/vtpg_pkg.sv =====
`default_nettype none
package vtpg_pkg;

	localparam int COORD_BITS    = 12;
	localparam int FRACTION_BITS = 16;

	localparam int MODE_BITS   = 1;
	localparam int STRIDE_BITS = 14;
	localparam int STEP_BITS   = 25;
	localparam int ADDR_BITS   = 26;
	localparam int LEVEL_BITS  = 8;
	localparam int CFG_DATA_BITS = 25;
	localparam int CFG_INDEX_BITS = 3;

	localparam int ACC_BITS  = FRACTION_BITS + 10;
	localparam int BAR_BITS  = FRACTION_BITS + 8;
	localparam int WIDE_BITS = ((ACC_BITS > STEP_BITS) ? ACC_BITS : STEP_BITS + 1) + 1;
	localparam int BARNUM_BITS = 4;

	localparam logic signed [WIDE_BITS-1:0] ACC_MAX_W =
		{{(WIDE_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [WIDE_BITS-1:0] ACC_MIN_W =
		{{(WIDE_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0] FULL_SCALE_A = ACC_BITS'(256) << FRACTION_BITS;
	localparam logic [WIDE_BITS-1:0] FULL_SCALE_W = WIDE_BITS'(256) << FRACTION_BITS;

	localparam logic [BARNUM_BITS-1:0] BAR_FIRST = BARNUM_BITS'(1);
	localparam logic [BARNUM_BITS-1:0] BAR_LIMIT = BARNUM_BITS'(8);
	localparam logic [BARNUM_BITS-1:0] BAR_LAST  = BARNUM_BITS'(7);
	localparam logic [BARNUM_BITS-1:0] BAR_RED   = BARNUM_BITS'(3'b001);
	localparam logic [BARNUM_BITS-1:0] BAR_BLUE  = BARNUM_BITS'(3'b010);
	localparam logic [BARNUM_BITS-1:0] BAR_GREEN = BARNUM_BITS'(3'b100);
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = LEVEL_BITS'(255);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_MODE = 3'd0,
		REG_FRAME_WIDTH  = 3'd1,
		REG_FRAME_HEIGHT = 3'd2,
		REG_LINE_STRIDE  = 3'd3,
		REG_COLUMN_STEP  = 3'd4,
		REG_ROW_STEP     = 3'd5
	} reg_index_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_RAMPS = 1'b0,
		MODE_BARS  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [COORD_BITS-1:0]  width;
		logic [COORD_BITS-1:0]  height;
		logic [STRIDE_BITS-1:0] stride;
		logic [STEP_BITS-1:0]   col_step;
		logic [STEP_BITS-1:0]   row_step;
	} cfg_t;

	typedef struct packed {
		logic [ACC_BITS-1:0]    red_acc;
		logic [ACC_BITS-1:0]    blue_acc;
		logic [ACC_BITS-1:0]    green_acc;
		logic [BAR_BITS-1:0]    bar_level;
		logic [BARNUM_BITS-1:0] bar_num;
	} pix_t;

	function automatic logic [ACC_BITS-1:0] sat_acc(input logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] r;
		r = v;
		if (v > ACC_MAX_W) begin
			r = ACC_MAX_W;
		end else if (v < ACC_MIN_W) begin
			r = ACC_MIN_W;
		end
		return r[ACC_BITS-1:0];
	endfunction

	function automatic logic [LEVEL_BITS-1:0] level_of(input logic signed [ACC_BITS-1:0] a);
		logic [LEVEL_BITS-1:0] r;
		r = a[FRACTION_BITS +: LEVEL_BITS];
		if (a < 0) begin
			r = '0;
		end else if (a >= FULL_SCALE_A) begin
			r = LEVEL_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vtpg_ramp.sv =====
`default_nettype none
module vtpg_ramp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic                          restart,
	input  wire vtpg_pkg::cfg_t                cfg,
	output vtpg_pkg::pix_t                     pix,
	output logic [vtpg_pkg::ADDR_BITS-1:0]     byte_address,
	output logic                               frame_done
);
	import vtpg_pkg::*;

	localparam int IDX_BITS = COORD_BITS + 2;

	logic [COORD_BITS-1:0]  col_q, row_q, col_e, row_e, col_n, row_n;
	logic [ADDR_BITS-1:0]   row_addr_q, row_addr_e, row_addr_n;
	logic [ACC_BITS-1:0]    red_q, blue_q, green_q, red_e, blue_e, green_e;
	logic [ACC_BITS-1:0]    red_n, blue_n, green_n;
	logic [BAR_BITS-1:0]    bar_q, bar_e, bar_n;
	logic [BARNUM_BITS-1:0] bnum_q, bnum_e, bnum_n;

	logic                   last_row, last_col;
	logic [IDX_BITS-1:0]    col_x, iv1, iv2, iv3;
	logic signed [WIDE_BITS-1:0] cstep_w, rstep_w, red_w, blue_w, green_w;
	logic [ACC_BITS-1:0]    red_up, red_dn, blue_up, blue_dn, green_up, green_dn;
	logic [WIDE_BITS-1:0]   bar_sum;

	always_comb begin
		col_e      = restart ? '0 : col_q;
		row_e      = restart ? '0 : row_q;
		row_addr_e = restart ? '0 : row_addr_q;
		red_e      = restart ? FULL_SCALE_A : red_q;
		blue_e     = restart ? '0 : blue_q;
		green_e    = restart ? '0 : green_q;
		bar_e      = restart ? '0 : bar_q;
		bnum_e     = restart ? BAR_FIRST : bnum_q;
	end

	assign pix.red_acc   = red_e;
	assign pix.blue_acc  = blue_e;
	assign pix.green_acc = green_e;
	assign pix.bar_level = bar_e;
	assign pix.bar_num   = bnum_e;

	assign last_row = ({1'b0, row_e} + 1'b1) >= {1'b0, cfg.height};
	assign last_col = ({1'b0, col_e} + 1'b1) >= {1'b0, cfg.width};
	assign frame_done = last_row && last_col;

	assign byte_address = row_addr_e + ADDR_BITS'(col_e) + ADDR_BITS'({col_e, 1'b0});

	assign col_x = IDX_BITS'(col_e);
	assign iv1   = IDX_BITS'(cfg.width >> 2);
	assign iv2   = iv1 << 1;
	assign iv3   = iv1 + iv2;

	assign cstep_w = $signed(WIDE_BITS'(cfg.col_step));
	assign rstep_w = $signed(WIDE_BITS'(cfg.row_step));
	assign red_w   = WIDE_BITS'($signed(red_e));
	assign blue_w  = WIDE_BITS'($signed(blue_e));
	assign green_w = WIDE_BITS'($signed(green_e));

	assign red_up   = sat_acc(red_w + cstep_w);
	assign red_dn   = sat_acc(red_w - cstep_w);
	assign blue_up  = sat_acc(blue_w + cstep_w);
	assign blue_dn  = sat_acc(blue_w - cstep_w);
	assign green_up = sat_acc(green_w + rstep_w);
	assign green_dn = sat_acc(green_w - rstep_w);
	assign bar_sum  = WIDE_BITS'(bar_e) + WIDE_BITS'(cfg.col_step);

	always_comb begin
		col_n      = col_e;
		row_n      = row_e;
		row_addr_n = row_addr_e;
		red_n      = red_e;
		blue_n     = blue_e;
		green_n    = green_e;
		bar_n      = bar_e;
		bnum_n     = bnum_e;
		if (!last_row) begin
			green_n    = (row_e < (cfg.height >> 1)) ? green_up : green_dn;
			row_n      = row_e + 1'b1;
			row_addr_n = row_addr_e + ADDR_BITS'(cfg.stride);
		end else if (last_col) begin
			col_n      = '0;
			row_n      = '0;
			row_addr_n = '0;
			red_n      = FULL_SCALE_A;
			blue_n     = '0;
			green_n    = '0;
			bar_n      = '0;
			bnum_n     = BAR_FIRST;
		end else begin
			if (col_x < iv1) begin
				blue_n = '0;
				red_n  = red_dn;
			end else if (col_x < iv2) begin
				blue_n = blue_up;
				red_n  = red_up;
			end else if (col_x < iv3) begin
				blue_n = blue_dn;
				red_n  = red_dn;
			end else begin
				blue_n = blue_up;
				red_n  = '0;
			end
			if (bar_sum >= FULL_SCALE_W) begin
				bar_n = '0;
				if (bnum_e < BAR_LIMIT) begin
					bnum_n = bnum_e + 1'b1;
				end
			end else begin
				bar_n = bar_sum[BAR_BITS-1:0];
			end
			col_n      = col_e + 1'b1;
			row_n      = '0;
			row_addr_n = '0;
			green_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_addr_q <= '0;
			red_q      <= FULL_SCALE_A;
			blue_q     <= '0;
			green_q    <= '0;
			bar_q      <= '0;
			bnum_q     <= BAR_FIRST;
		end else if (advance) begin
			col_q      <= col_n;
			row_q      <= row_n;
			row_addr_q <= row_addr_n;
			red_q      <= red_n;
			blue_q     <= blue_n;
			green_q    <= green_n;
			bar_q      <= bar_n;
			bnum_q     <= bnum_n;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vtpg_color.sv =====
`default_nettype none
module vtpg_color (
	input  wire vtpg_pkg::mode_t               mode,
	input  wire vtpg_pkg::pix_t                pix,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]    red_level,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]    blue_level,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]    green_level
);
	import vtpg_pkg::*;

	logic [LEVEL_BITS-1:0] bar_lv;

	assign bar_lv = pix.bar_level[FRACTION_BITS +: LEVEL_BITS];

	always_comb begin
		case (mode)
			MODE_RAMPS: begin
				red_level   = level_of($signed(pix.red_acc));
				blue_level  = level_of($signed(pix.blue_acc));
				green_level = level_of($signed(pix.green_acc));
			end
			MODE_BARS: begin
				if (pix.bar_num > BAR_LAST) begin
					red_level   = LEVEL_MAX;
					blue_level  = LEVEL_MAX;
					green_level = LEVEL_MAX;
				end else begin
					red_level   = ((pix.bar_num & BAR_RED) != '0) ? bar_lv : '0;
					blue_level  = ((pix.bar_num & BAR_BLUE) != '0) ? bar_lv : '0;
					green_level = ((pix.bar_num & BAR_GREEN) != '0) ? bar_lv : '0;
				end
			end
			default: begin
				red_level   = '0;
				blue_level  = '0;
				green_level = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/video_test_pattern_generator_unit.sv =====
`default_nettype none
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------------
// in      | in_valid / in_ready  | restart
// out     | out_valid / out_ready| byte_address, red_level, blue_level, green_level,
//         |                      | frame_done
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One pixel per cycle unless out_ready stalls the output: a beat taken on in is shown on out the next cycle.
// The pixel is computed between the frame state registers and the result register.
// in_ready is high while the result register is empty or being drained.
// Reset leaves the result register empty, the registers at their defaults and
// the frame at its first pixel.
module video_test_pattern_generator_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 restart,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [vtpg_pkg::ADDR_BITS-1:0]            byte_address,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]           red_level,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]           blue_level,
	output logic [vtpg_pkg::LEVEL_BITS-1:0]           green_level,
	output logic                                      frame_done,
	input  wire logic                                 cfg_we,
	input  wire logic [vtpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [vtpg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import vtpg_pkg::*;

	cfg_t                  cfg_q;
	pix_t                  pix;
	logic                  accept;
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  addr_c, byte_address_q;
	logic [LEVEL_BITS-1:0] red_c, blue_c, green_c;
	logic [LEVEL_BITS-1:0] red_level_q, blue_level_q, green_level_q;
	logic                  done_c, frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_RAMPS;
			cfg_q.width    <= COORD_BITS'(640);
			cfg_q.height   <= COORD_BITS'(480);
			cfg_q.stride   <= STRIDE_BITS'(1920);
			cfg_q.col_step <= STEP_BITS'(26214);
			cfg_q.row_step <= STEP_BITS'(69905);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_MODE: cfg_q.mode     <= mode_t'(cfg_data[MODE_BITS-1:0]);
				REG_FRAME_WIDTH:  cfg_q.width    <= cfg_data[COORD_BITS-1:0];
				REG_FRAME_HEIGHT: cfg_q.height   <= cfg_data[COORD_BITS-1:0];
				REG_LINE_STRIDE:  cfg_q.stride   <= cfg_data[STRIDE_BITS-1:0];
				REG_COLUMN_STEP:  cfg_q.col_step <= cfg_data[STEP_BITS-1:0];
				REG_ROW_STEP:     cfg_q.row_step <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	vtpg_ramp u_ramp (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.restart      (restart),
		.cfg          (cfg_q),
		.pix          (pix),
		.byte_address (addr_c),
		.frame_done   (done_c)
	);

	vtpg_color u_color (
		.mode        (cfg_q.mode),
		.pix         (pix),
		.red_level   (red_c),
		.blue_level  (blue_c),
		.green_level (green_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept || (out_valid_q && !out_ready);
		end
	end

	// hold the beat until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_address_q <= addr_c;
			red_level_q    <= red_c;
			blue_level_q   <= blue_c;
			green_level_q  <= green_c;
			frame_done_q   <= done_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_address = byte_address_q;
	assign red_level    = red_level_q;
	assign blue_level   = blue_level_q;
	assign green_level  = green_level_q;
	assign frame_done   = frame_done_q;

endmodule
`default_nettype wire
